### sv/ubde_pkg.sv
package ubde_pkg;

  localparam int BaudW = 24;
  localparam int NumW  = 28;
  localparam int Div1W = 24;
  localparam int Div2W = 18;
  localparam int CandW = 17;

  localparam logic [2:0] FamAm    = 3'd0;
  localparam logic [2:0] FamBm    = 3'd1;
  localparam logic [2:0] Fam2232c = 3'd2;
  localparam logic [2:0] FamR     = 3'd3;
  localparam logic [2:0] Fam2232h = 3'd4;
  localparam logic [2:0] Fam4232h = 3'd5;
  localparam logic [2:0] Fam232h  = 3'd6;
  localparam logic [2:0] Fam230x  = 3'd7;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatTol  = 2'd2;

  localparam int AmClk       = 24000000;
  localparam int StdClk      = 48000000;
  localparam int HsClk       = 120000000;
  localparam int HsThreshDiv = 16383;
  localparam int HsThresh    = HsClk / HsThreshDiv;

  localparam logic [NumW-1:0] AmNum     = NumW'(AmClk);
  localparam logic [NumW-1:0] StdScaled = NumW'(StdClk * 16 / 16);
  localparam logic [NumW-1:0] HsScaled  = NumW'(HsClk / 10 * 16);

  localparam logic [BaudW-1:0] StdBase   = BaudW'(StdClk / 16);
  localparam logic [BaudW-1:0] StdBase15 = BaudW'(StdClk / 24);
  localparam logic [BaudW-1:0] StdBase2  = BaudW'(StdClk / 32);
  localparam logic [BaudW-1:0] HsBase    = BaudW'(HsClk / 10);
  localparam logic [BaudW-1:0] HsBase15  = BaudW'(HsClk / 15);
  localparam logic [BaudW-1:0] HsBase2   = BaudW'(HsClk / 20);

  localparam logic [CandW-1:0] AmMaxDiv  = 17'h1FFF8;
  localparam logic [27:0]      CeilTrig  = 28'h0020000;
  localparam logic [Div2W-1:0] CeilVal   = 18'h1FFFF;
  localparam logic [16:0]      AmSpecial = 17'h04001;
  localparam logic [28:0]      TolNum    = 29'd21;
  localparam logic [28:0]      TolDen    = 29'd20;

  typedef struct packed {
    logic zero;
    logic am;
    logic hs;
    logic hs_fast;
  } flags_t;

  typedef struct packed {
    logic [15:0]      value;
    logic [15:0]      index;
    logic [BaudW-1:0] baud;
    logic [1:0]       status;
  } res_t;

  function automatic logic [2:0] eighth_code(input logic [2:0] f);
    logic [2:0] c;
    case (f)
      3'd0: c = 3'd0;
      3'd1: c = 3'd3;
      3'd2: c = 3'd2;
      3'd3: c = 3'd4;
      3'd4: c = 3'd1;
      3'd5: c = 3'd5;
      3'd6: c = 3'd6;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] am_up(input logic [2:0] f);
    logic [1:0] c;
    case (f)
      3'd3: c = 2'd1;
      3'd5: c = 2'd3;
      3'd6: c = 2'd2;
      3'd7: c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] am_down(input logic [2:0] f);
    logic [1:0] c;
    case (f)
      3'd3: c = 2'd1;
      3'd5: c = 2'd1;
      3'd6: c = 2'd2;
      3'd7: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // Integer part in the low bits, fraction code in bits 16..14.
  function automatic logic [16:0] encode(input logic [Div2W-1:0] d);
    return {2'b00, d[17:3]} | {eighth_code(d[2:0]), 14'b0};
  endfunction

  // One AM candidate divisor from the lowered base divisor dd and the trial ti.
  function automatic logic [CandW-1:0] am_cand(input logic [24:0] dd, input logic [24:0] ti);
    logic [24:0]      tu;
    logic [CandW-1:0] r;
    tu = ti + {23'b0, am_up(ti[2:0])};
    if (ti <= 25'd8) begin
      r = 17'd8;
    end else if (dd < 25'd16) begin
      r = 17'd16;
    end else if (tu > {8'b0, AmMaxDiv}) begin
      r = AmMaxDiv;
    end else begin
      r = tu[CandW-1:0];
    end
    return r;
  endfunction

endpackage

### sv/ubde_div_cell.sv
module ubde_div_cell #(
  parameter int NW = 28,
  parameter int DW = 24,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_nq,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_nq,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] nq_next;

  // One restoring step: the top numerator bit moves into the remainder and
  // the quotient bit enters at the bottom of the numerator register.
  always_comb begin
    trial    = {in_rem, in_nq[NW-1]};
    diff     = trial - {1'b0, in_div};
    ge       = trial >= {1'b0, in_div};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    nq_next  = {in_nq[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_nq   <= nq_next;
      out_rem  <= rem_next;
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

### sv/ubde_div_chain.sv
module ubde_div_chain #(
  parameter int NW = 28,
  parameter int DW = 24,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [DW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic          v    [0:NW];
  logic [NW-1:0] nq   [0:NW];
  logic [DW-1:0] rem  [0:NW];
  logic [DW-1:0] dv   [0:NW];
  logic [SW-1:0] side [0:NW];

  assign v[0]    = in_valid;
  assign nq[0]   = in_num;
  assign rem[0]  = '0;
  assign dv[0]   = in_div;
  assign side[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_cell
    ubde_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[k]),
      .in_nq    (nq[k]),
      .in_rem   (rem[k]),
      .in_div   (dv[k]),
      .in_side  (side[k]),
      .out_valid(v[k+1]),
      .out_nq   (nq[k+1]),
      .out_rem  (rem[k+1]),
      .out_div  (dv[k+1]),
      .out_side (side[k+1])
    );
  end

  assign out_valid = v[NW];
  assign out_quot  = nq[NW];
  assign out_div   = dv[NW];
  assign out_side  = side[NW];

endmodule

### sv/uart_baud_divisor_encoder.sv
// Baud rate divisor encoder for a family of USB-to-UART bridge chips.
// Input channel: requested_baud with in_valid/in_ready. Output channel: one
// word per request (divisor_value, divisor_index, achieved_baud,
// result_status) with out_valid/out_ready. chip_family is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle,
// which the block itself does not enforce; reset sets it to BM. A request passes
// through an input register, a 28-cell chain that divides the base clock by the
// request, one stage that rounds and picks candidate divisors, two parallel
// 28-cell chains that divide back to the achieved rate, two result stages and
// the output register. Each cell produces one quotient bit, so one request
// enters every cycle while the pipeline is not frozen. When the receiver stalls,
// the word after the held one lands in a skid register and the whole pipeline
// then freezes, in_ready dropping, until the held word is taken and the skid
// word moves into the output register. Reset empties the pipeline, the output
// and the skid register; nothing needs to be cleared in memory.
module uart_baud_divisor_encoder
  import ubde_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [BaudW-1:0] requested_baud,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      divisor_value,
  output logic [15:0]      divisor_index,
  output logic [BaudW-1:0] achieved_baud,
  output logic [1:0]       result_status
);

  localparam int Side1W = $bits(flags_t);

  logic [2:0] chip_family;
  logic       en;
  logic       accept;
  logic       skid_valid;
  res_t       skid;
  res_t       out_word;
  logic       push;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_family <= FamBm;
    end else if (cfg_wr_en) begin
      chip_family <= cfg_wr_data;
    end
  end

  // Input stage.
  logic             s0_valid;
  logic [BaudW-1:0] s0_baud;
  flags_t           s0_flags;
  flags_t           s0_flags_next;
  logic [NumW-1:0]  s0_num;
  logic [NumW-1:0]  s0_num_next;
  logic [NumW-1:0]  baud_x10;

  assign en     = !skid_valid;
  assign accept = in_valid && en;

  always_comb begin
    baud_x10              = NumW'(requested_baud) * NumW'(10);
    s0_flags_next.zero    = requested_baud == '0;
    s0_flags_next.hs      = chip_family == Fam2232h || chip_family == Fam4232h ||
                            chip_family == Fam232h;
    s0_flags_next.am      = chip_family == FamAm;
    s0_flags_next.hs_fast = s0_flags_next.hs && (baud_x10 > NumW'(HsThresh));
    if (s0_flags_next.am) begin
      s0_num_next = AmNum;
    end else if (s0_flags_next.hs_fast) begin
      s0_num_next = HsScaled;
    end else begin
      s0_num_next = StdScaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_baud  <= requested_baud;
      s0_flags <= s0_flags_next;
      s0_num   <= s0_num_next;
    end
  end

  // First division: base clock over the request.
  logic              d1_valid;
  logic [NumW-1:0]   d1_quot;
  logic [Div1W-1:0]  d1_div;
  logic [Side1W-1:0] d1_side;

  ubde_div_chain #(.NW(NumW), .DW(Div1W), .SW(Side1W)) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s0_valid),
    .in_num   (s0_num),
    .in_div   (s0_baud),
    .in_side  (s0_flags),
    .out_valid(d1_valid),
    .out_quot (d1_quot),
    .out_div  (d1_div),
    .out_side (d1_side)
  );

  // Rounding and candidate divisors.
  flags_t           m_flags_in;
  logic [NumW-1:0]  m_round;
  logic [Div2W-1:0] m_best;
  logic [24:0]      m_dd;
  logic [CandW-1:0] m_t0;
  logic [CandW-1:0] m_t1;
  logic [NumW-1:0]  m_num_a_next;
  logic [Div2W-1:0] m_div_a_next;
  logic [NumW-1:0]  m_num_b_next;

  always_comb begin
    m_flags_in = flags_t'(d1_side);
    m_round    = (d1_quot + NumW'(1)) >> 1;
    m_best     = (m_round > CeilTrig) ? CeilVal : m_round[Div2W-1:0];
    m_dd       = d1_quot[24:0] - {23'b0, am_down(d1_quot[2:0])};
    m_t0       = am_cand(m_dd, m_dd);
    m_t1       = am_cand(m_dd, m_dd + 25'd1);
    m_num_b_next = AmNum + NumW'(m_t1 >> 1);
    if (m_flags_in.am) begin
      m_num_a_next = AmNum + NumW'(m_t0 >> 1);
      m_div_a_next = {1'b0, m_t0};
    end else begin
      m_num_a_next = m_flags_in.hs_fast ? HsScaled : StdScaled;
      m_div_a_next = m_best;
    end
  end

  logic              m_valid;
  logic [NumW-1:0]   m_num_a;
  logic [Div2W-1:0]  m_div_a;
  logic [NumW-1:0]   m_num_b;
  logic [CandW-1:0]  m_div_b;
  logic [BaudW-1:0]  m_baud;
  flags_t            m_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num_a <= m_num_a_next;
      m_div_a <= m_div_a_next;
      m_num_b <= m_num_b_next;
      m_div_b <= m_t1;
      m_baud  <= d1_div;
      m_flags <= m_flags_in;
    end
  end

  // Second division: back to the achieved rate; AM checks two candidates.
  logic             da_valid;
  logic [NumW-1:0]  da_quot;
  logic [Div2W-1:0] da_div;
  logic [BaudW-1:0] da_baud;
  logic             db_valid;
  logic [NumW-1:0]  db_quot;
  logic [CandW-1:0] db_div;
  logic [3:0]       db_side;

  ubde_div_chain #(.NW(NumW), .DW(Div2W), .SW(BaudW)) u_div2a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_num   (m_num_a),
    .in_div   (m_div_a),
    .in_side  (m_baud),
    .out_valid(da_valid),
    .out_quot (da_quot),
    .out_div  (da_div),
    .out_side (da_baud)
  );

  ubde_div_chain #(.NW(NumW), .DW(CandW), .SW($bits(flags_t))) u_div2b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .in_num   (m_num_b),
    .in_div   (m_div_b),
    .in_side  (m_flags),
    .out_valid(db_valid),
    .out_quot (db_quot),
    .out_div  (db_div),
    .out_side (db_side)
  );

  // Selection and encoding.
  flags_t           f_flags;
  logic [NumW-1:0]  f_round;
  logic [BaudW-1:0] f_got;
  logic [16:0]      f_enc;
  logic [17:0]      f_enc_full;
  logic [BaudW-1:0] f_est0;
  logic [BaudW-1:0] f_est1;
  logic [BaudW-1:0] f_diff0;
  logic [BaudW-1:0] f_diff1;
  logic [CandW-1:0] f_bd;
  logic [BaudW-1:0] f_b;
  logic [BaudW-1:0] f_b15;
  logic [BaudW-1:0] f_b2;

  always_comb begin
    f_flags = flags_t'(db_side);
    f_round = (da_quot + NumW'(1)) >> 1;
    f_est0  = da_quot[BaudW-1:0];
    f_est1  = db_quot[BaudW-1:0];
    f_diff0 = (f_est0 < da_baud) ? da_baud - f_est0 : f_est0 - da_baud;
    f_diff1 = (f_est1 < da_baud) ? da_baud - f_est1 : f_est1 - da_baud;
    f_b     = f_flags.hs_fast ? HsBase : StdBase;
    f_b15   = f_flags.hs_fast ? HsBase15 : StdBase15;
    f_b2    = f_flags.hs_fast ? HsBase2 : StdBase2;
    f_bd    = da_div[CandW-1:0];
    if (f_flags.am) begin
      // Ties keep the lower candidate.
      if (f_diff1 < f_diff0) begin
        f_bd  = db_div;
        f_got = f_est1;
      end else begin
        f_got = f_est0;
      end
      f_enc = encode({1'b0, f_bd});
      if (f_enc == 17'd1) begin
        f_enc = '0;
      end else if (f_enc == AmSpecial) begin
        f_enc = 17'd1;
      end
    end else if (da_baud >= f_b) begin
      f_enc = 17'd0;
      f_got = f_b;
    end else if (da_baud >= f_b15) begin
      f_enc = 17'd1;
      f_got = f_b15;
    end else if (da_baud >= f_b2) begin
      f_enc = 17'd2;
      f_got = f_b2;
    end else begin
      f_enc = encode(da_div);
      f_got = f_round[BaudW-1:0];
    end
    f_enc_full = {f_flags.hs_fast, f_enc};
  end

  logic             f1_valid;
  logic [15:0]      f1_value;
  logic [15:0]      f1_index;
  logic [BaudW-1:0] f1_got;
  logic [BaudW-1:0] f1_baud;
  logic             f1_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= da_valid && db_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_value <= f_enc_full[15:0];
      f1_index <= f_flags.hs ? {6'b0, f_enc_full[17:16], 8'b0} : {15'b0, f_enc_full[16]};
      f1_got   <= f_got;
      f1_baud  <= da_baud;
      f1_zero  <= f_flags.zero;
    end
  end

  // Tolerance check.
  logic [28:0] t_a21;
  logic [28:0] t_a20;
  logic [28:0] t_r21;
  logic [28:0] t_r20;
  logic        t_off;
  res_t        f2_next;

  always_comb begin
    t_a21 = {5'b0, f1_got} * TolNum;
    t_a20 = {5'b0, f1_got} * TolDen;
    t_r21 = {5'b0, f1_baud} * TolNum;
    t_r20 = {5'b0, f1_baud} * TolDen;
    if ({f1_got, 1'b0} < {1'b0, f1_baud}) begin
      t_off = 1'b1;
    end else if (f1_got < f1_baud) begin
      t_off = t_a21 < t_r20;
    end else begin
      t_off = t_r21 < t_a20;
    end
    if (f1_zero) begin
      f2_next = '{value: '0, index: '0, baud: '0, status: StatZero};
    end else begin
      f2_next = '{value: f1_value, index: f1_index, baud: f1_got,
                  status: t_off ? StatTol : StatOk};
    end
  end

  logic f2_valid;
  res_t f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2 <= f2_next;
    end
  end

  // Output register and skid register.
  assign push     = en && f2_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word <= skid;
      end else if (push) begin
        out_word <= f2;
      end
    end else if (push) begin
      skid <= f2;
    end
  end

  assign divisor_value = out_word.value;
  assign divisor_index = out_word.index;
  assign achieved_baud = out_word.baud;
  assign result_status = out_word.status;

endmodule

### sv/ubde_checker.sv
module ubde_checker
  import ubde_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [BaudW-1:0] requested_baud,
  input logic             out_valid,
  input logic             out_ready,
  input logic [15:0]      divisor_value,
  input logic [15:0]      divisor_index,
  input logic [BaudW-1:0] achieved_baud,
  input logic [1:0]       result_status
);

  // A zero request reports nothing but its status.
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status == StatZero |->
      divisor_value == '0 && divisor_index == '0 && achieved_baud == '0)
    else $error("zero request word carries nonzero fields");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(requested_baud))
    else $error("waiting request word changed");

  a_ok_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status == StatOk |-> achieved_baud != '0)
    else $error("accepted word reports a zero rate");

  a_rate_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> achieved_baud <= HsBase)
    else $error("achieved rate above the fastest base clock");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divisor_value) &&
      $stable(achieved_baud) && $stable(result_status))
    else $error("stalled word changed");

endmodule

bind uart_baud_divisor_encoder ubde_checker u_ubde_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .requested_baud(requested_baud),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .divisor_value (divisor_value),
  .divisor_index (divisor_index),
  .achieved_baud (achieved_baud),
  .result_status (result_status)
);
